// ===== rtl/efuse_logical_map_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the efuse logical map decoder
// Shared concurrent assertion forms, sampled on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef EFUSE_LOGICAL_MAP_DECODER_UNIT_MACROS_SVH
`define EFUSE_LOGICAL_MAP_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define EFLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/efld_pkg.sv =====
// ----------------------------------------------------------------------------
// efld_pkg
// Shared constants and types of the efuse logical map decoder.
// ----------------------------------------------------------------------------
package efld_pkg;

  localparam int EFUSE_BYTES = 1024;
  localparam int PHYS_W      = $clog2(EFUSE_BYTES + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARGIN   = 2'd2;

  localparam logic [9:0]  TARGET_OFFSET_RST = 10'd202;
  localparam logic [10:0] MAP_LIMIT_RST     = 11'd208;
  localparam logic [9:0]  STOP_MARGIN_RST   = 10'd8;

  localparam logic [7:0] BYTE_BLANK   = 8'hFF;
  localparam logic [4:0] EXT_HDR_CODE = 5'h0F;
  localparam logic [3:0] EXT_SKIP     = 4'hF;

  typedef struct packed {
    logic [9:0]  target_offset;
    logic [10:0] map_limit;
    logic [9:0]  stop_margin;
  } efld_cfg_t;

  typedef struct packed {
    logic       write_valid;
    logic [9:0] map_address;
    logic [7:0] map_data;
    logic       finished;
    logic [7:0] option_value;
  } efld_result_t;

endpackage

// ===== rtl/efld_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// efld_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module efld_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [efld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efld_pkg::CFG_DATA_W-1:0] cfg_data,
  output efld_pkg::efld_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_offset <= efld_pkg::TARGET_OFFSET_RST;
      cfg.map_limit     <= efld_pkg::MAP_LIMIT_RST;
      cfg.stop_margin   <= efld_pkg::STOP_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efld_pkg::REG_TARGET_OFFSET: cfg.target_offset <= cfg_data[9:0];
        efld_pkg::REG_MAP_LIMIT:     cfg.map_limit     <= cfg_data[10:0];
        efld_pkg::REG_STOP_MARGIN:   cfg.stop_margin   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/efld_parser.sv =====
// ----------------------------------------------------------------------------
// efld_parser
// Packet walk state and its update for each efuse byte.
// ----------------------------------------------------------------------------
module efld_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   command,
  input  logic [7:0]             efuse_byte,
  input  logic                   read_failed,
  input  efld_pkg::efld_cfg_t    cfg,
  output logic                   res_valid,
  output efld_pkg::efld_result_t res
);

  typedef enum logic [1:0] {PH_HEADER, PH_EXT, PH_DATA, PH_DONE} phase_t;

  localparam int PW = efld_pkg::PHYS_W;

  phase_t        parse_phase, parse_phase_next;
  logic [7:0]    saved_header, saved_header_next;
  logic [9:0]    block_base, block_base_next;
  logic [3:0]    absent_words, absent_words_next;
  logic [1:0]    word_position, word_position_next;
  logic          byte_in_word, byte_in_word_next;
  logic [PW-1:0] physical_count, physical_count_next;
  logic [7:0]    tracked_byte, tracked_byte_next;

  logic [7:0]  b;
  logic        at_limit;
  logic        past_target;
  logic [10:0] stop_point;
  logic [9:0]  idx;
  logic [2:0]  first_word;
  logic [2:0]  following_word;
  logic        wv;
  logic        fin;

  function automatic logic [2:0] next_present(input logic [3:0] mask, input logic [2:0] from);
    logic [2:0] r;
    logic       found;
    r     = 3'd4;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && (3'(i) >= from) && !mask[i]) begin
        r     = 3'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    parse_phase_next    = parse_phase;
    saved_header_next   = saved_header;
    block_base_next     = block_base;
    absent_words_next   = absent_words;
    word_position_next  = word_position;
    byte_in_word_next   = byte_in_word;
    physical_count_next = physical_count;
    tracked_byte_next   = tracked_byte;
    wv                  = 1'b0;
    fin                 = 1'b0;
    res                 = '0;

    b = read_failed ? efld_pkg::BYTE_BLANK : efuse_byte;
    if (physical_count < PW'(efld_pkg::EFUSE_BYTES)) begin
      physical_count_next = physical_count + PW'(1);
    end
    at_limit   = physical_count_next >= PW'(efld_pkg::EFUSE_BYTES);
    stop_point = {1'b0, cfg.target_offset} + {1'b0, cfg.stop_margin};
    idx        = block_base + {7'd0, word_position, byte_in_word};
    first_word = next_present(b[3:0], 3'd0);
    following_word = next_present(absent_words, {1'b0, word_position} + 3'd1);

    case (parse_phase)
      PH_HEADER: begin
        if (b == efld_pkg::BYTE_BLANK) begin
          fin = 1'b1;
        end else if (b[4:0] == efld_pkg::EXT_HDR_CODE) begin
          saved_header_next = b;
          parse_phase_next  = PH_EXT;
        end else begin
          block_base_next = {3'd0, b[7:4], 3'd0};
        end
      end
      PH_EXT: begin
        if (b[3:0] == efld_pkg::EXT_SKIP) begin
          parse_phase_next = PH_HEADER;
          fin              = at_limit;
        end else begin
          block_base_next = {b[7:4], saved_header[7:5], 3'd0};
        end
      end
      PH_DATA: begin
        if ({1'b0, idx} < cfg.map_limit) begin
          wv              = 1'b1;
          res.map_address = idx;
          res.map_data    = b;
          if (idx == cfg.target_offset) begin
            tracked_byte_next = b;
          end
        end
        if (!byte_in_word) begin
          byte_in_word_next = 1'b1;
        end else begin
          byte_in_word_next = 1'b0;
          if (following_word[2]) begin
            word_position_next = 2'd0;
            parse_phase_next   = PH_HEADER;
            fin = ({1'b0, block_base} > stop_point) || at_limit;
          end else begin
            word_position_next = following_word[1:0];
          end
        end
      end
      default: ;
    endcase

    // open the word mask of a new packet
    if ((parse_phase == PH_HEADER && b != efld_pkg::BYTE_BLANK
         && b[4:0] != efld_pkg::EXT_HDR_CODE)
        || (parse_phase == PH_EXT && b[3:0] != efld_pkg::EXT_SKIP)) begin
      absent_words_next = b[3:0];
      byte_in_word_next = 1'b0;
      if (first_word[2]) begin
        word_position_next = 2'd0;
        parse_phase_next   = PH_HEADER;
        fin = ({1'b0, block_base_next} > stop_point) || at_limit;
      end else begin
        word_position_next = first_word[1:0];
        parse_phase_next   = PH_DATA;
      end
    end

    past_target = fin;
    if (past_target) begin
      parse_phase_next = PH_DONE;
      res.option_value = (tracked_byte_next == efld_pkg::BYTE_BLANK) ? 8'd0
                                                                     : tracked_byte_next;
    end
    res.write_valid = wv;
    res.finished    = fin;

    res_valid = accept && command && (parse_phase != PH_DONE) && (wv || fin);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && !command)) begin
      parse_phase    <= PH_HEADER;
      saved_header   <= '0;
      block_base     <= '0;
      absent_words   <= 4'hF;
      word_position  <= '0;
      byte_in_word   <= 1'b0;
      physical_count <= '0;
      tracked_byte   <= efld_pkg::BYTE_BLANK;
    end else if (accept && parse_phase != PH_DONE) begin
      parse_phase    <= parse_phase_next;
      saved_header   <= saved_header_next;
      block_base     <= block_base_next;
      absent_words   <= absent_words_next;
      word_position  <= word_position_next;
      byte_in_word   <= byte_in_word_next;
      physical_count <= physical_count_next;
      tracked_byte   <= tracked_byte_next;
    end
  end

endmodule

// ===== rtl/efld_out_buf.sv =====
// ----------------------------------------------------------------------------
// efld_out_buf
// Two-entry result buffer between the parser and the output channel.
// ----------------------------------------------------------------------------
module efld_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  efld_pkg::efld_result_t push_word,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output efld_pkg::efld_result_t head
);

  efld_pkg::efld_result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/efuse_logical_map_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// efuse_logical_map_decoder_unit
// Walks physical efuse bytes and parses the packets into
// logical map writes, ending with the option byte found at target_offset.
// Every accepted byte is parsed in the same cycle by the packet state
// update, so the block takes one byte per clock unless in_stall is high. Results land in a
// two-deep output buffer; in_stall rises only while both entries hold words
// that the output side has not yet taken. Bytes that cause no write and no
// finish, restarts, and bytes after the walk ended produce no output word.
// Configuration writes take effect from the next byte.
// ----------------------------------------------------------------------------
module efuse_logical_map_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [efld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [7:0]                      efuse_byte,
  input  logic                            read_failed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            write_valid,
  output logic [9:0]                      map_address,
  output logic [7:0]                      map_data,
  output logic                            finished,
  output logic [7:0]                      option_value
);

  efld_pkg::efld_cfg_t    cfg;
  efld_pkg::efld_result_t res;
  efld_pkg::efld_result_t head;
  logic                   res_valid;
  logic                   full;
  logic                   accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  efld_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efld_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .efuse_byte  (efuse_byte),
    .read_failed (read_failed),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  efld_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign write_valid  = head.write_valid;
  assign map_address  = head.map_address;
  assign map_data     = head.map_data;
  assign finished     = head.finished;
  assign option_value = head.option_value;

endmodule

// ===== rtl/efld_checker.sv =====
// ----------------------------------------------------------------------------
// efld_checker
// Port-level checks of the efuse logical map decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "efuse_logical_map_decoder_unit_macros.svh"

module efld_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       write_valid,
  input logic [9:0] map_address,
  input logic [7:0] map_data,
  input logic       finished,
  input logic [7:0] option_value
);

  `EFLD_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable({write_valid, map_address, map_data, finished, option_value}), "stalled output word changed")
  `EFLD_ASSERT_NOW(a_word_has_content, out_valid, write_valid || finished, "output word carries neither write nor finish")
  `EFLD_ASSERT_NOW(a_option_only_at_end, out_valid && !finished, option_value == 8'd0, "option value set before finish")
  `EFLD_ASSERT_NOW(a_quiet_fields, out_valid && !write_valid, map_address == 10'd0 && map_data == 8'd0, "write fields set without a write")

endmodule

bind efuse_logical_map_decoder_unit efld_checker u_efld_checker (.*);
